@@ hdl/swmf_pkg.sv @@
// Shared types and constants for the sliding-window maximum filter.
package swmf_pkg;

	localparam int CFG_W = 7;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-1:0] ADDR_WINDOW_LENGTH = 2'd0;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic insert;
	} cell_cmd_t;

endpackage

@@ hdl/swmf_cell.sv @@
// One queue cell: holds a value, its row position and a valid flag.
module swmf_cell
	import swmf_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int POS_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] new_data,
	input  logic [POS_W-1:0]      new_pos,
	input  logic                  nbr_valid,
	input  logic [DATA_WIDTH-1:0] nbr_data,
	input  logic [POS_W-1:0]      nbr_pos,
	input  logic                  prev_keep,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic [POS_W-1:0]      pos,
	output logic                  keep
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [POS_W-1:0]      pos_q;
	logic                  take;

	// keep entries strictly greater than the incoming sample
	assign keep = valid_q && ($signed(data_q) > $signed(new_data));
	assign take = !keep && prev_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= nbr_valid;
		end else if (cmd.insert) begin
			valid_q <= keep || take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			data_q <= nbr_data;
			pos_q  <= nbr_pos;
		end else if (cmd.insert && take) begin
			data_q <= new_data;
			pos_q  <= new_pos;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign pos   = pos_q;

endmodule

@@ hdl/sliding_window_maximum_filter.sv @@
// Sliding-window maximum filter: monotonic queue held in a row of cells.
// After a request is accepted the sequencer enters the work state and shifts the
// cell row once for each front entry that leaves the window (normally 0 or 1); it
// then inserts the sample, waiting while a held result blocks the insert, and takes
// no new request until it is back in the idle state. Reset clears the queue,
// position, fill flag and output valid; window_length resets to 1.
module sliding_window_maximum_filter
	import swmf_pkg::*;
#(
	parameter int MAX_WINDOW = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample
	input  logic [0:0]                          s_axis_tuser,  // start_of_row
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // window_max
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [APB_AW-1:0]                   paddr,
	input  logic [APB_DW-1:0]                   pwdata,
	output logic [APB_DW-1:0]                   prdata,
	output logic                                pready
);

	localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int POS_W = $clog2(MAX_WINDOW) + 1;
	localparam int CMP_W = (POS_W > CFG_W) ? POS_W : CFG_W;
	localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WINDOW);

	state_t                state_q, state_d;
	cell_cmd_t             cmd;
	logic [CFG_W-1:0]      wl_q;
	logic [DATA_WIDTH-1:0] sample_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      row_q;
	logic                  filled_q;
	logic                  m_valid_q;
	logic [DATA_WIDTH-1:0] m_data_q;

	logic                  in_acc;
	logic                  out_free;
	logic                  drop;
	logic                  fill_hit;
	logic [CMP_W-1:0]      wl_ext;
	logic [POS_W-1:0]      w_eff;
	logic [POS_W-1:0]      age;
	logic [DATA_WIDTH-1:0] front;

	logic                  c_valid [MAX_WINDOW];
	logic [DATA_WIDTH-1:0] c_data  [MAX_WINDOW];
	logic [POS_W-1:0]      c_pos   [MAX_WINDOW];
	logic                  c_keep  [MAX_WINDOW];

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? APB_DW'(wl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= CFG_W'(1);
		end else if (psel && penable && pwrite && pready &&
		             paddr == ADDR_WINDOW_LENGTH) begin
			wl_q <= pwdata[CFG_W-1:0];
		end
	end

	assign wl_ext = CMP_W'(wl_q);
	assign w_eff  = (wl_q == '0) ? POS_W'(1) :
	                (wl_ext > MAXW_C) ? POS_W'(MAX_WINDOW) : POS_W'(wl_ext);

	// cell row
	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			logic                  nv;
			logic [DATA_WIDTH-1:0] nd;
			logic [POS_W-1:0]      np;
			logic                  pk;
			if (gi == MAX_WINDOW - 1) begin : g_last
				assign nv = 1'b0;
				assign nd = '0;
				assign np = '0;
			end else begin : g_mid
				assign nv = c_valid[gi+1];
				assign nd = c_data[gi+1];
				assign np = c_pos[gi+1];
			end
			if (gi == 0) begin : g_first
				assign pk = 1'b1;
			end else begin : g_next
				assign pk = c_keep[gi-1];
			end
			swmf_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.POS_W     (POS_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.new_data (sample_q),
				.new_pos  (pos_q),
				.nbr_valid(nv),
				.nbr_data (nd),
				.nbr_pos  (np),
				.prev_keep(pk),
				.valid    (c_valid[gi]),
				.data     (c_data[gi]),
				.pos      (c_pos[gi]),
				.keep     (c_keep[gi])
			);
		end
	endgenerate

	assign age      = pos_q - c_pos[0];
	assign drop     = c_valid[0] && (age >= w_eff);
	assign fill_hit = ({1'b0, pos_q} + 1'b1) >= {1'b0, w_eff};
	assign front    = c_keep[0] ? c_data[0] : sample_q;
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.clear = s_axis_tuser[0];
					state_d   = ST_WORK;
				end
			end
			ST_WORK: begin
				if (drop) begin
					cmd.shift = 1'b1;
				end else if (out_free) begin
					cmd.insert = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			pos_q     <= '0;
			filled_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				pos_q <= s_axis_tuser[0] ? '0 : row_q;
				if (s_axis_tuser[0]) begin
					filled_q <= 1'b0;
				end
			end
			if (cmd.insert) begin
				row_q <= pos_q + 1'b1;
				if (fill_hit) begin
					filled_q <= 1'b1;
				end
			end
			if (cmd.insert && (filled_q || fill_hit)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= s_axis_tdata[DATA_WIDTH-1:0];
		end
		if (cmd.insert && (filled_q || fill_hit)) begin
			m_data_q <= front;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TDATA_W'(m_data_q);

endmodule

@@ hdl/swmf_checker.sv @@
// Port-level checks for the sliding-window maximum filter, bound to the top level.
module swmf_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// a new result follows a busy cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without processing cycle");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata >> DATA_WIDTH) == '0))
		else $error("nonzero padding in result");

endmodule

bind sliding_window_maximum_filter swmf_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_swmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ test/sliding_window_maximum_filter_tb.sv @@
// Self-checking testbench for the sliding-window maximum filter.
`timescale 1ns / 1ps

module sliding_window_maximum_filter_tb;
	import swmf_pkg::*;

	localparam int DEPTH = 64;
	localparam int POS_MOD = 2 * DEPTH;
	localparam int DW = 32;
	localparam int SETTLE = 150;
	localparam int LIMIT = 400000;
	localparam int HOLD_LEN = 400;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	typedef struct packed {
		logic        sor;
		logic [DW-1:0] sample;
	} sample_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DW-1:0]     s_axis_tdata = '0;  // sample
	logic [0:0]        s_axis_tuser = '0;  // start_of_row
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DW-1:0]     m_axis_tdata;       // window_max
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sliding_window_maximum_filter dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	sample_req_t       sample_reqs[$];
	logic [DW-1:0]     max_expected[$];
	logic signed [DW-1:0] dq_val[DEPTH];
	logic [6:0]        dq_pos[DEPTH];
	int                dq_head = 0;
	int                dq_count = 0;
	int                row_pos = 0;
	bit                filled = 0;
	logic [CFG_W-1:0]  win_len = 7'd1;

	int  idle_mode = IDLE_NONE;
	int  hold_order = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	bit  accepted = 0;
	int  errors = 0;
	int  n_items = 0;
	int  n_results = 0;
	int  n_settings = 0;
	int  cycles = 0;

	// Advance the window by one sample and record the maximum it yields.
	function automatic void advance_window(input logic signed [DW-1:0] smp, input logic sor);
		int w;
		int pos;
		int gap;
		w = int'(win_len);
		if (w == 0) w = 1;
		if (w > DEPTH) w = DEPTH;
		if (sor) begin
			dq_head = 0;
			dq_count = 0;
			row_pos = 0;
			filled = 0;
		end
		pos = row_pos;
		while (dq_count > 0) begin
			gap = (pos + POS_MOD - int'(dq_pos[dq_head])) % POS_MOD;
			if (gap < w) break;
			dq_head = (dq_head + 1) % DEPTH;
			dq_count--;
		end
		while (dq_count > 0 && dq_val[(dq_head + dq_count - 1) % DEPTH] <= smp)
			dq_count--;
		if (dq_count >= DEPTH) begin
			dq_head = (dq_head + 1) % DEPTH;
			dq_count--;
		end
		dq_val[(dq_head + dq_count) % DEPTH] = smp;
		dq_pos[(dq_head + dq_count) % DEPTH] = pos[6:0];
		dq_count++;
		if (pos + 1 >= w) filled = 1;
		row_pos = (pos + 1) % POS_MOD;
		if (filled) max_expected = {max_expected, dq_val[dq_head]};
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[sliding_window_maximum_filter] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		accepted = s_axis_tvalid && s_axis_tready;
		if (accepted) begin
			n_items++;
			advance_window(s_axis_tdata, s_axis_tuser[0]);
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || accepted)) begin
			if (sample_reqs.size() == 0 ||
			    (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 86) ||
			    (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				sample_req_t r;
				r = sample_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= r.sample;
				s_axis_tuser <= r.sor;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_order != hold_served) begin
			hold_served = hold_order;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_mode == IDLE_RECV) begin
			m_axis_tready <= ($urandom_range(0, 99) >= 86);
		end else if (idle_mode == IDLE_BOTH) begin
			m_axis_tready <= ($urandom_range(0, 99) >= 8);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (max_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d",
					$realtime, $signed(m_axis_tdata));
			end else begin
				logic [DW-1:0] want;
				want = max_expected.pop_front();
				if (m_axis_tdata !== want) begin
					errors++;
					$display("%0t: window_max mismatch, expected %0d, actual %0d",
						$realtime, $signed(want), $signed(m_axis_tdata));
				end
			end
		end
	end

	task automatic wait_drained();
		do @(posedge clk);
		while (!(sample_reqs.size() == 0 && !s_axis_tvalid && max_expected.size() == 0));
	endtask

	task automatic write_window(input logic [CFG_W-1:0] val);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_WINDOW_LENGTH;
		pwdata <= {{(APB_DW-CFG_W){1'b0}}, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		win_len = val;
		n_settings++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic push_sample(input logic [DW-1:0] smp, input logic sor);
		sample_req_t r;
		r.sample = smp;
		r.sor = sor;
		sample_reqs = {sample_reqs, r};
	endtask

	// Queue rows of patterned samples; continue the current row when asked.
	task automatic fill_rows(input int n, input bit keep_row);
		int made;
		int w;
		int len;
		int pat;
		logic [DW-1:0] v;
		logic [DW-1:0] stp;
		bit first;
		made = 0;
		first = !keep_row;
		w = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : int'(win_len));
		while (made < n) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(130, 260);
				1, 2: len = $urandom_range(1, w);
				default: len = $urandom_range(w, w + 20);
			endcase
			pat = $urandom_range(0, 3);
			v = $urandom;
			stp = $urandom_range(0, 1000);
			for (int i = 0; i < len && made < n; i++) begin
				case (pat)
					0: v = $urandom;
					1: v = $urandom_range(0, 6) - 3;
					2: v = v - stp;
					default: v = v + stp;
				endcase
				if ($urandom_range(0, 19) == 0)
					v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
				push_sample(v, (i == 0 && first) || $urandom_range(0, 99) < 3);
				first = 1;
				made++;
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] windows[12];
		windows = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd1, 7'd65, 7'd3, 7'd0, 7'd64, 7'd0, 7'd1, 7'd0};
		windows[7] = CFG_W'($urandom_range(4, 63));
		windows[9] = CFG_W'($urandom_range(4, 63));
		windows[11] = CFG_W'($urandom_range(1, 64));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of one, stream without a leading row start
		push_sample(32'h7fff_ffff, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h0000_0000, 1'b0);
		push_sample(32'hffff_ffff, 1'b0);
		push_sample(32'h0000_0001, 1'b0);
		write_window(7'd4);
		push_sample(-32'sd5, 1'b1);
		push_sample(-32'sd5, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'd7, 1'b0);
		push_sample(32'd7, 1'b0);
		push_sample(32'd3, 1'b0);
		push_sample(32'd2, 1'b0);
		push_sample(32'd1, 1'b0);
		push_sample(32'd0, 1'b0);
		push_sample(32'h7fff_ffff, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h8000_0000, 1'b1);
		push_sample(32'h5555_aaaa, 1'b0);
		write_window(7'd2);
		// shrink inside the running row
		push_sample(32'd5, 1'b0);
		push_sample(32'd4, 1'b0);
		push_sample(32'haaaa_5555, 1'b0);

		for (int ph = 0; ph < 12; ph++) begin
			write_window(windows[ph]);
			idle_mode = ph % 4;
			if (ph == 0) hold_order++;
			fill_rows(35, ph % 3 == 1);
			wait_drained();
			fill_rows(35, 1'b1);
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (max_expected.size() != 0) errors++;
		$display("run covered %0d samples and %0d window maxima over %0d window settings",
			n_items, n_results, n_settings);
		$display("settings included zero, saturating and full windows, ties and long rows");
		if (errors == 0) begin
			$display("[sliding_window_maximum_filter] OK");
		end else begin
			$display("[sliding_window_maximum_filter] ERROR");
		end
		$finish;
	end

endmodule
